// File: hw/rtl/adsr_envelope_gain_macros.svh
// Assertion macros for the ADSR envelope gain block.
// Used by adsr_envelope_gain; expects clk and arst_n in scope.
`ifndef ADSR_ENVELOPE_GAIN_MACROS_SVH
`define ADSR_ENVELOPE_GAIN_MACROS_SVH
`ifndef ASSERT_OFF
`define AEG_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define AEG_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define AEG_ASSERT_NOW(lbl, pre, post)
`define AEG_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// File: hw/rtl/aeg_pkg.sv
// Shared constants, types and helpers for the ADSR envelope gain block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aeg_pkg;
	localparam int INDEX_BITS_DEF = 20;
	localparam int ZERO_TAIL_DEF  = 1000;
	localparam int SAMPLE_BITS    = 16;
	localparam int FRAC_BITS      = 16;
	localparam int Q_BITS         = 12;
	localparam int CFG_IDX_BITS   = 3;
	localparam logic [15:0] AMP_RESET = 16'd4096;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_AMPLITUDE   = 3'd0,
		CFG_ATTACK_LEN  = 3'd1,
		CFG_DECAY_LEN   = 3'd2,
		CFG_RELEASE_LEN = 3'd3,
		CFG_END_INDEX   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic att;
		logic dec;
		logic rel;
		logic zero;
	} region_t;

	// floor(p / 4096) saturated to 16 bits
	function automatic logic signed [15:0] sat_q12(input logic signed [32:0] p);
		logic signed [32:0] q;
		logic signed [15:0] r;
		q = p >>> Q_BITS;
		if (q > 33'sd32767)
			r = 16'sh7fff;
		else if (q < -33'sd32768)
			r = 16'sh8000;
		else
			r = q[15:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/aeg_if.sv
// Stream interfaces for the ADSR envelope gain block: sample in, sample out.
// Depends on aeg_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface aeg_in_if import aeg_pkg::*; #(parameter int INDEX_BITS = INDEX_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [INDEX_BITS-1:0]        sample_index;
	modport source (output valid, sample_in, sample_index, input ready);
	modport sink (input valid, sample_in, sample_index, output ready);
endinterface

interface aeg_out_if import aeg_pkg::*;;
	logic                         valid;
	logic                         ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	modport source (output valid, sample_out, input ready);
	modport sink (input valid, sample_out, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/adsr_envelope_gain.sv
// Throughput one sample per cycle while the output is ready or the pipeline has a bubble.
// Stage 1 finds the regions, stages 2-17 are a 16-stage pipelined divider per ramp region
// (one quotient bit per stage), stage 18 forms gains, stages 19-21 apply them and the zero tail.
// Each stage advances when the next one is empty or moving, so bubbles close up.
// Reset clears all valid bits and loads the register reset values.
// Depends on aeg_pkg, aeg_if and adsr_envelope_gain_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "adsr_envelope_gain_macros.svh"
module adsr_envelope_gain import aeg_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int ZERO_TAIL  = ZERO_TAIL_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [((INDEX_BITS > 16) ? INDEX_BITS : 16)-1:0] cfg_data,
	aeg_in_if.sink                       in_ch,
	aeg_out_if.source                    out_ch
);
	localparam int IB = INDEX_BITS;
	localparam int TW = IB + 17;
	localparam int NS = FRAC_BITS + 5;
	localparam int ND = FRAC_BITS;

	logic [15:0]   amp_q;
	logic [IB-1:0] att_len_q, dec_len_q, rel_len_q, end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q     <= AMP_RESET;
			att_len_q <= '0;
			dec_len_q <= '0;
			rel_len_q <= '0;
			end_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AMPLITUDE:   amp_q     <= cfg_data[15:0];
				CFG_ATTACK_LEN:  att_len_q <= cfg_data[IB-1:0];
				CFG_DECAY_LEN:   dec_len_q <= cfg_data[IB-1:0];
				CFG_RELEASE_LEN: rel_len_q <= cfg_data[IB-1:0];
				CFG_END_INDEX:   end_q     <= cfg_data[IB-1:0];
				default: ;
			endcase
		end
	end

	logic [IB-1:0] rel_len, rel_start;
	logic [IB-1:0] lens [3];
	assign rel_len   = (rel_len_q > end_q) ? end_q : rel_len_q;
	assign rel_start = end_q - rel_len;
	assign lens[0]   = att_len_q;
	assign lens[1]   = dec_len_q;
	assign lens[2]   = rel_len;

	// stage valids and enables
	logic vld_s [1:NS];
	logic en    [1:NS+1];

	always_comb begin
		en[NS+1] = out_ch.ready;
		for (int i = NS; i >= 1; i--)
			en[i] = !vld_s[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++)
				vld_s[i] <= 1'b0;
		end else begin
			if (en[1])
				vld_s[1] <= in_ch.valid;
			for (int i = 2; i <= NS; i++)
				if (en[i])
					vld_s[i] <= vld_s[i-1];
		end
	end

	assign in_ch.ready = en[1];

	// stage 1: region decode
	logic [IB-1:0] k;
	logic [IB:0]   ad_end;
	logic [TW-1:0] tail_end;
	region_t       reg_in;
	assign k        = in_ch.sample_index;
	assign ad_end   = {1'b0, att_len_q} + {1'b0, dec_len_q};
	assign tail_end = TW'(end_q) + TW'(ZERO_TAIL);
	assign reg_in.att  = k < att_len_q;
	assign reg_in.dec  = (k >= att_len_q) && ({1'b0, k} < ad_end);
	assign reg_in.rel  = (k >= rel_start) && (k < end_q);
	assign reg_in.zero = (k >= end_q) && (TW'(k) < tail_end);

	logic signed [15:0] smp_s1;
	region_t            rg_s1;
	logic [IB-1:0]      x_s1 [3];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			smp_s1  <= in_ch.sample_in;
			rg_s1   <= reg_in;
			x_s1[0] <= reg_in.att ? k : '0;
			x_s1[1] <= reg_in.dec ? k - att_len_q : '0;
			x_s1[2] <= reg_in.rel ? k - rel_start : '0;
		end
	end

	// stages 2..17: restoring divider, one quotient bit per stage and lane
	logic signed [15:0]   smp_d [ND];
	region_t              rg_d  [ND];
	logic [IB-1:0]        rem_d [ND][3];
	logic [FRAC_BITS-1:0] quo_d [ND][3];

	for (genvar j = 0; j < ND; j++) begin : g_div
		logic [IB-1:0]        rem_in [3];
		logic [FRAC_BITS-1:0] quo_in [3];
		logic [IB:0]          r2     [3];
		logic                 ge     [3];
		if (j == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					rem_in[l] = x_s1[l];
					quo_in[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					rem_in[l] = rem_d[j-1][l];
					quo_in[l] = quo_d[j-1][l];
				end
			end
		end
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				r2[l] = {rem_in[l], 1'b0};
				ge[l] = r2[l] >= {1'b0, lens[l]};
			end
		end
		always_ff @(posedge clk) begin
			if (en[j+2]) begin
				smp_d[j] <= (j == 0) ? smp_s1 : smp_d[(j == 0) ? 0 : j-1];
				rg_d[j]  <= (j == 0) ? rg_s1 : rg_d[(j == 0) ? 0 : j-1];
				for (int l = 0; l < 3; l++) begin
					rem_d[j][l] <= ge[l] ? IB'(r2[l] - {1'b0, lens[l]}) : IB'(r2[l]);
					quo_d[j][l] <= {quo_in[l][FRAC_BITS-2:0], ge[l]};
				end
			end
		end
	end

	// stage 18: gains
	logic [FRAC_BITS-1:0] f_att, f_dec, f_rel;
	logic [16:0]          inv_dec, inv_rel;
	logic [31:0]          p_att;
	logic [32:0]          p_dec;
	logic [33:0]          sum_dec;
	assign f_att   = quo_d[ND-1][0];
	assign f_dec   = quo_d[ND-1][1];
	assign f_rel   = quo_d[ND-1][2];
	assign inv_dec = 17'h10000 - {1'b0, f_dec};
	assign inv_rel = 17'h10000 - {1'b0, f_rel};
	assign p_att   = 32'(amp_q) * 32'(f_att);
	assign p_dec   = 33'(amp_q) * 33'(inv_dec);
	assign sum_dec = 34'(p_dec) + 34'({f_dec, 12'b0});

	logic signed [15:0] smp_s18;
	region_t            rg_s18;
	logic [15:0]        ga_s18, gd_s18;
	logic [12:0]        gr_s18;

	always_ff @(posedge clk) begin
		if (en[ND+2]) begin
			smp_s18 <= smp_d[ND-1];
			rg_s18  <= rg_d[ND-1];
			ga_s18  <= p_att[31:16];
			gd_s18  <= sum_dec[31:16];
			gr_s18  <= inv_rel[16:4];
		end
	end

	// stages 19..21: apply attack, decay, release and the zero tail
	logic signed [32:0] m_att, m_dec, m_rel;
	assign m_att = 33'(smp_s18) * 33'($signed({1'b0, ga_s18}));

	logic signed [15:0] smp_s19, smp_s20, smp_s21;
	region_t            rg_s19, rg_s20;
	logic [15:0]        gd_s19;
	logic [12:0]        gr_s19, gr_s20;

	always_ff @(posedge clk) begin
		if (en[ND+3]) begin
			smp_s19 <= rg_s18.att ? sat_q12(m_att) : smp_s18;
			rg_s19  <= rg_s18;
			gd_s19  <= gd_s18;
			gr_s19  <= gr_s18;
		end
	end

	assign m_dec = 33'(smp_s19) * 33'($signed({1'b0, gd_s19}));

	always_ff @(posedge clk) begin
		if (en[ND+4]) begin
			smp_s20 <= rg_s19.dec ? sat_q12(m_dec) : smp_s19;
			rg_s20  <= rg_s19;
			gr_s20  <= gr_s19;
		end
	end

	assign m_rel = 33'(smp_s20) * 33'($signed({4'b0, gr_s20}));

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			if (rg_s20.zero)
				smp_s21 <= '0;
			else if (rg_s20.rel)
				smp_s21 <= sat_q12(m_rel);
			else
				smp_s21 <= smp_s20;
		end
	end

	assign out_ch.valid      = vld_s[NS];
	assign out_ch.sample_out = smp_s21;

	`AEG_ASSERT_NOW(a_ready_when_out_empty, !vld_s[NS], in_ch.ready)
	`AEG_ASSERT_NXT(a_accept_fills_s1, in_ch.valid && in_ch.ready, vld_s[1])
	`AEG_ASSERT_NXT(a_tail_is_zero, en[NS] && vld_s[NS-1] && rg_s20.zero, smp_s21 == 16'sd0)
endmodule
`default_nettype wire

// File: bench/adsr_envelope_gain_tb.sv
// Self-checking bench for adsr_envelope_gain: random sample streams over many envelope settings.
// Checks each output transaction against an internal gain predictor.
// Depends on aeg_pkg and aeg_if from the RTL tree.
`timescale 1ns / 1ps
module adsr_envelope_gain_tb;
	import aeg_pkg::*;

	localparam int IDX_W = 20;
	localparam longint IDX_MAX = (64'd1 << IDX_W) - 1;
	localparam int TAIL = 1000;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic [15:0] amp;
		logic [19:0] att;
		logic [19:0] dec;
		logic [19:0] rel;
		logic [19:0] endi;
	} env_cfg_t;

	typedef struct {
		logic signed [15:0] smp;
		logic [19:0] idx;
	} smp_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [19:0] cfg_data;

	aeg_in_if #(.INDEX_BITS(IDX_W)) in_ch();
	aeg_out_if out_ch();

	adsr_envelope_gain dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	env_cfg_t env;
	smp_item_t pending[$];
	logic signed [15:0] expected_out[$];
	int errors = 0;
	int n_in = 0;
	int n_out = 0;
	int n_phases = 0;
	int idle_cycles = 0;
	bit took = 0;
	int gap = 0;
	int burst = 0;
	int stall_mode = 0;
	int stall_left = 0;

	initial begin
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_AMPLITUDE;
		cfg_data = '0;
		in_ch.valid = 0;
		in_ch.sample_in = '0;
		in_ch.sample_index = '0;
		out_ch.ready = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [15:0] step_gain(logic signed [15:0] s, longint g);
		longint p;
		longint q;
		p = longint'(s) * g;
		q = p >>> 12;
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	function automatic logic signed [15:0] envelope_out(smp_item_t it, env_cfg_t c);
		longint k;
		longint a;
		longint d;
		longint e;
		longint r;
		longint rs;
		longint f;
		logic signed [15:0] s;
		k = it.idx;
		a = c.att;
		d = c.dec;
		e = c.endi;
		r = (c.rel > c.endi) ? e : longint'(c.rel);
		rs = e - r;
		s = it.smp;
		if (k < a) begin
			f = (k * 65536) / a;
			s = step_gain(s, (longint'(c.amp) * f) >> 16);
		end
		if (k >= a && k < a + d) begin
			f = ((k - a) * 65536) / d;
			s = step_gain(s, (longint'(c.amp) * (65536 - f) + 4096 * f) >> 16);
		end
		if (k >= rs && k < e) begin
			f = ((k - rs) * 65536) / r;
			s = step_gain(s, (65536 - f) >> 4);
		end
		if (k >= e && k < e + TAIL)
			s = 0;
		return s;
	endfunction

	task automatic report(string what, logic signed [15:0] got, logic signed [15:0] exp);
		$display("MISMATCH %s: got %0d expected %0d (output transaction %0d)",
			what, got, exp, n_out);
		errors++;
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic load_env(env_cfg_t c);
		wait (pending.size() == 0 && expected_out.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_AMPLITUDE, {4'd0, c.amp});
		write_reg(CFG_ATTACK_LEN, c.att);
		write_reg(CFG_DECAY_LEN, c.dec);
		write_reg(CFG_RELEASE_LEN, c.rel);
		write_reg(CFG_END_INDEX, c.endi);
		write_reg(CFG_UNUSED, 20'($urandom));
		env = c;
		n_phases++;
	endtask

	function automatic logic [19:0] rand_len();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return $urandom_range(1, 64);
			2: return $urandom_range(1, 300);
			3: return $urandom_range(1, 4096);
			4: return IDX_MAX;
			5: return 1;
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic smp_item_t rand_item(env_cfg_t c);
		smp_item_t it;
		longint base;
		longint k;
		case ($urandom_range(0, 9))
			0: it.smp = 16'sh7fff;
			1: it.smp = 16'sh8000;
			2: it.smp = 16'($urandom_range(0, 15)) - 16'sd8;
			default: it.smp = 16'($urandom);
		endcase
		case ($urandom_range(0, 6))
			0: base = 0;
			1: base = c.att;
			2: base = longint'(c.att) + c.dec;
			3: base = longint'(c.endi) - ((c.rel > c.endi) ? c.endi : c.rel);
			4: base = c.endi;
			5: base = longint'(c.endi) + TAIL;
			default: base = -1;
		endcase
		k = base + $urandom_range(0, 32) - 16;
		if (base < 0 || k < 0 || k > IDX_MAX || $urandom_range(0, 9) == 0)
			k = 20'($urandom);
		it.idx = k[19:0];
		return it;
	endfunction

	task automatic push_item(logic signed [15:0] s, logic [19:0] k);
		smp_item_t it;
		it.smp = s;
		it.idx = k;
		pending.push_back(it);
	endtask

	initial begin
		env_cfg_t c;
		env = '{amp: AMP_RESET, att: 0, dec: 0, rel: 0, endi: 0};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset values: only the zero tail at the start is active
		push_item(16'sd1234, 0);
		push_item(-16'sd77, 999);
		push_item(16'sh7fff, 1000);
		push_item(16'sh8000, 20'hfffff);

		// attack, then decay overlapping release, with a loud peak
		c = '{amp: 16'd40000, att: 16, dec: 16, rel: 16, endi: 40};
		load_env(c);
		push_item(16'sh7fff, 0);
		push_item(16'sh7fff, 1);
		push_item(16'sh8000, 15);
		push_item(16'sh7fff, 16);
		push_item(16'sh8000, 24);
		push_item(16'sh7fff, 31);
		push_item(-16'sd1, 32);
		push_item(16'sh7fff, 39);
		push_item(16'sh7fff, 40);
		push_item(16'sh8000, 1039);
		push_item(16'sd5, 1040);

		// release longer than end index, zero attack/decay
		c = '{amp: 16'd0, att: 0, dec: 0, rel: 20'hfffff, endi: 100};
		load_env(c);
		push_item(16'sh7fff, 0);
		push_item(16'sh8000, 50);
		push_item(-16'sd3, 99);
		push_item(16'sh7fff, 1100);

		// all registers at maximum
		c = '{amp: 16'hffff, att: 20'hfffff, dec: 20'hfffff, rel: 20'hfffff,
			endi: 20'hfffff};
		load_env(c);
		push_item(16'sh7fff, 20'hffffe);
		push_item(16'sh8000, 20'hfffff);
		push_item(16'sh7fff, 0);

		for (int p = 0; p < 12; p++) begin
			c.amp = ($urandom_range(0, 3) == 0) ? AMP_RESET : 16'($urandom);
			if (p == 0) c.amp = 16'hffff;
			if (p == 1) c.amp = 0;
			c.att = rand_len();
			c.dec = rand_len();
			c.rel = rand_len();
			c.endi = ($urandom_range(0, 1) == 0) ? rand_len()
				: 20'(longint'(c.att) + c.dec + $urandom_range(0, 64));
			load_env(c);
			for (int i = 0; i < 150; i++)
				pending.push_back(rand_item(c));
		end

		wait (pending.size() == 0 && expected_out.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d settings, %0d samples in, %0d samples checked.",
			n_phases, n_in, n_out);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		took = in_ch.valid && in_ch.ready;
		if (took) begin
			expected_out.push_back(envelope_out(pending[0], env));
			void'(pending.pop_front());
			n_in++;
		end
		if (out_ch.valid && out_ch.ready) begin
			if (expected_out.size() == 0) begin
				report("unexpected output", out_ch.sample_out, 0);
			end else begin
				if (out_ch.sample_out !== expected_out[0])
					report("sample_out", out_ch.sample_out, expected_out[0]);
				void'(expected_out.pop_front());
			end
			n_out++;
		end
		if (took || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles = 0;
		else if (++idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d pending, %0d awaited",
				pending.size(), expected_out.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!(in_ch.valid && !took)) begin
				if (gap > 0) begin
					gap--;
					in_ch.valid <= 0;
				end else if (pending.size() > 0) begin
					in_ch.valid <= 1;
					in_ch.sample_in <= pending[0].smp;
					in_ch.sample_index <= pending[0].idx;
					if (burst > 0)
						burst--;
					else begin
						burst = $urandom_range(0, 40);
						gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else
					in_ch.valid <= 0;
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(10, 200);
			end else
				stall_left--;
			case (stall_mode)
				0: out_ch.ready <= 1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				2: out_ch.ready <= ($urandom_range(0, 1) != 0);
				default: out_ch.ready <= ((stall_left % 7) < 2);
			endcase
		end
	end
endmodule
